>>> src/assert_macros.svh
// Assertion helpers shared by the RTL; clk and arst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/i128_pkg.sv
`timescale 1ns / 1ps
package i128_pkg;
	localparam int W  = 128;
	localparam int HW = 64;
	localparam int SHW = 8;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_AND  = 4'd4,
		OP_OR   = 4'd5,
		OP_XOR  = 4'd6,
		OP_NOT  = 4'd7,
		OP_NEG  = 4'd8,
		OP_SHL  = 4'd9,
		OP_SAR  = 4'd10,
		OP_ROL1 = 4'd11,
		OP_ROR1 = 4'd12
	} op_t;

	// One slot of the cell chain. x/y/z are shared:
	// div: x remainder, y dividend in / quotient out, z divisor magnitude
	// mul: x accumulator, y multiplier, z multiplicand
	typedef struct packed {
		logic         valid;
		op_t          op;
		logic [W-1:0] res;
		logic         dz;
		logic         eq;
		logic         qneg;
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic [W-1:0] z;
	} stage_t;
endpackage

>>> src/i128_in_if.sv
`timescale 1ns / 1ps
interface i128_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [63:0] a_high;
	logic [63:0] a_low;
	logic [63:0] b_high;
	logic [63:0] b_low;
	logic [7:0]  shift_amount;

	modport source (output valid, opcode, a_high, a_low, b_high, b_low, shift_amount,
		input ready);
	modport sink (input valid, opcode, a_high, a_low, b_high, b_low, shift_amount,
		output ready);
endinterface

>>> src/i128_out_if.sv
`timescale 1ns / 1ps
interface i128_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	logic        div_by_zero;
	logic        equal;

	modport source (output valid, result_high, result_low, div_by_zero, equal,
		input ready);
	modport sink (input valid, result_high, result_low, div_by_zero, equal,
		output ready);
endinterface

>>> src/int128_alu.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// int128_alu: 128-bit two's complement ALU (add, sub, mul, signed div, logic ops,
// shifts, rotates) with an equality flag. Every operation takes the same path:
// a combinational entry stage, a chain of 128 cell registers and an output
// register. One operation is accepted every cycle while the output register
// holds no untaken result; results leave in input order. Each cell does one
// shift-add multiply step or one restoring divide step, which is what sets the
// chain length. The whole chain stalls together when the output register holds
// an untaken result.
module int128_alu import i128_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	i128_in_if.sink   in_ch,
	i128_out_if.source out_ch
);
	stage_t chain [0:W];
	logic   en;

	// output register
	logic         valid_q;
	logic [W-1:0] res_q;
	logic         dz_q;
	logic         eq_q;
	logic [W-1:0] fin;

	// chain advances unless a finished result is waiting
	assign en          = !valid_q || out_ch.ready;
	assign in_ch.ready = en;

	i128_pre u_pre (
		.valid        (in_ch.valid),
		.opcode       (in_ch.opcode),
		.a            ({in_ch.a_high, in_ch.a_low}),
		.b            ({in_ch.b_high, in_ch.b_low}),
		.shift_amount (in_ch.shift_amount),
		.st           (chain[0])
	);

	for (genvar i = 0; i < W; i++) begin : g_cell
		i128_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	// final select; quotient sign fix, zero on divide by zero
	always_comb begin
		case (chain[W].op)
			OP_MUL:  fin = chain[W].x;
			OP_DIV: begin
				if (chain[W].dz) begin
					fin = '0;
				end else if (chain[W].qneg) begin
					fin = ~chain[W].y + W'(1);
				end else begin
					fin = chain[W].y;
				end
			end
			default: fin = chain[W].res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= chain[W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= fin;
			dz_q  <= chain[W].dz;
			eq_q  <= chain[W].eq;
		end
	end

	assign out_ch.valid       = valid_q;
	assign out_ch.result_high = res_q[W-1:HW];
	assign out_ch.result_low  = res_q[HW-1:0];
	assign out_ch.div_by_zero = dz_q;
	assign out_ch.equal       = eq_q;

	`CHK_IMPLY(a_dz_zero, valid_q && dz_q, res_q == '0, "divide by zero result not zero")
	`CHK_NEXT(a_stall_last, valid_q && !out_ch.ready, $stable(chain[W].valid),
		"chain moved under stall")
endmodule

>>> src/i128_pre.sv
`timescale 1ns / 1ps
module i128_pre import i128_pkg::*; (
	input  logic           valid,
	input  logic [3:0]     opcode,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	input  logic [SHW-1:0] shift_amount,
	output stage_t         st
);
	logic         na, nb;
	logic [W-1:0] amag, bmag;
	logic [W-1:0] fill;
	logic         long_sh;

	assign na      = a[W-1];
	assign nb      = b[W-1];
	assign amag    = na ? (~a + W'(1)) : a;
	assign bmag    = nb ? (~b + W'(1)) : b;
	assign fill    = {W{a[W-1]}};
	assign long_sh = (shift_amount >= SHW'(W));

	always_comb begin
		st       = '0;
		st.valid = valid;
		st.op    = op_t'(opcode);
		st.eq    = (a == b);
		case (op_t'(opcode))
			OP_ADD:  st.res = a + b;
			OP_SUB:  st.res = a - b;
			OP_MUL: begin
				st.y = b;
				st.z = a;
			end
			OP_DIV: begin
				st.dz   = (b == '0);
				st.qneg = na ^ nb;
				st.y    = amag;
				st.z    = bmag;
			end
			OP_AND:  st.res = a & b;
			OP_OR:   st.res = a | b;
			OP_XOR:  st.res = a ^ b;
			OP_NOT:  st.res = ~a;
			OP_NEG:  st.res = ~a + W'(1);
			OP_SHL:  st.res = long_sh ? '0 : (a << shift_amount[$clog2(W)-1:0]);
			OP_SAR:  st.res = long_sh ? fill
				: W'($signed(a) >>> shift_amount[$clog2(W)-1:0]);
			OP_ROL1: st.res = {a[W-2:0], a[W-1]};
			OP_ROR1: st.res = {a[0], a[W-1:1]};
			default: st.res = '0;
		endcase
	end
endmodule

>>> src/i128_cell.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module i128_cell import i128_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  stage_t d,
	output stage_t q
);
	stage_t     nx;
	stage_t     data_q;
	logic       valid_q;
	logic [W-1:0] rsh;
	logic [W:0]   diff;

	// one shift-add (mul) or one restoring step (div) per cell
	always_comb begin
		nx   = d;
		rsh  = {d.x[W-2:0], d.y[W-1]};
		diff = {1'b0, rsh} - {1'b0, d.z};
		case (d.op)
			OP_MUL: begin
				if (d.y[0]) begin
					nx.x = d.x + d.z;
				end
				nx.y = {1'b0, d.y[W-1:1]};
				nx.z = {d.z[W-2:0], 1'b0};
			end
			OP_DIV: begin
				if (!diff[W]) begin
					nx.x = diff[W-1:0];
					nx.y = {d.y[W-2:0], 1'b1};
				end else begin
					nx.x = rsh;
					nx.y = {d.y[W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nx;
		end
	end

	always_comb begin
		q       = data_q;
		q.valid = valid_q;
	end

	`CHK_NEXT(a_cell_hold, !en, $stable(valid_q), "cell valid moved while stalled")
endmodule

>>> test/alu_checker.sv
`timescale 1ns / 1ps
module alu_checker import i128_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	i128_in_if     in_ch,
	i128_out_if    out_ch,
	output int     errors,
	output int     pending
);
	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        dz;
		logic        eq;
	} alu_out_t;

	alu_out_t expected_q[$];

	assign pending = expected_q.size();

	function automatic alu_out_t alu_result(logic [3:0] opc, logic [127:0] a,
		logic [127:0] b, logic [7:0] sh);
		alu_out_t     r;
		logic [127:0] v, ma, mb, q;
		v = '0;
		r.dz = 1'b0;
		case (opc)
			OP_ADD: v = a + b;
			OP_SUB: v = a - b;
			OP_MUL: v = a * b;
			OP_DIV: begin
				if (b == '0) begin
					r.dz = 1'b1;
				end else begin
					// magnitudes, so the most negative value divides as 2^127
					ma = a[127] ? -a : a;
					mb = b[127] ? -b : b;
					q = ma / mb;
					v = (a[127] != b[127]) ? -q : q;
				end
			end
			OP_AND:  v = a & b;
			OP_OR:   v = a | b;
			OP_XOR:  v = a ^ b;
			OP_NOT:  v = ~a;
			OP_NEG:  v = -a;
			OP_SHL:  v = (sh >= 8'd128) ? '0 : a << sh;
			OP_SAR:  v = (sh >= 8'd128) ? {128{a[127]}} : 128'($signed(a) >>> sh);
			OP_ROL1: v = {a[126:0], a[127]};
			OP_ROR1: v = {a[0], a[127:1]};
			default: v = '0;
		endcase
		r.hi = v[127:64];
		r.lo = v[63:0];
		r.eq = (a == b);
		return r;
	endfunction

	task automatic report(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t mismatch %s: expected %h got %h", $realtime, field, want, got);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk) begin
		alu_out_t e;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				expected_q.push_back(alu_result(in_ch.opcode,
					{in_ch.a_high, in_ch.a_low}, {in_ch.b_high, in_ch.b_low},
					in_ch.shift_amount));
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t result transfer with nothing expected", $realtime);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (out_ch.result_high !== e.hi) report("result_high", e.hi, out_ch.result_high);
					if (out_ch.result_low !== e.lo) report("result_low", e.lo, out_ch.result_low);
					if (out_ch.div_by_zero !== e.dz)
						report("div_by_zero", 64'(e.dz), 64'(out_ch.div_by_zero));
					if (out_ch.equal !== e.eq)
						report("equal", 64'(e.eq), 64'(out_ch.equal));
				end
			end
		end
	end
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top import i128_pkg::*; ();
	localparam int LIMIT = 200000;
	localparam int RAND_ITEMS = 950;

	localparam logic [127:0] MIN_NEG = {1'b1, 127'b0};
	localparam logic [127:0] ALL_ONE = '1;

	logic clk;
	logic arst_n;
	int   cyc;
	int   errors;
	int   pending;

	i128_in_if  in_ch();
	i128_out_if out_ch();

	int128_alu u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	alu_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	initial cyc = 0;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// operand mix: extremes, small values and sign-extended 64-bit values often, fully random the rest
	function automatic logic [127:0] pick_operand();
		logic [127:0] v;
		v = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = ALL_ONE;
			2: v = MIN_NEG;
			3: v = 128'd1;
			4: v = 128'($urandom_range(0, 1000));
			5: v = -128'($urandom_range(1, 1000));
			6: v = {64'($signed(v[63])) , v[63:0]};  // fits in 64 bits, sign extended
			default: ;
		endcase
		return v;
	endfunction

	// one transfer on the input channel; caller owns valid between items
	task automatic send_op(logic [3:0] opc, logic [127:0] a, logic [127:0] b,
		logic [7:0] sh);
		@(negedge clk);
		in_ch.valid        <= 1'b1;
		in_ch.opcode       <= opc;
		in_ch.a_high       <= a[127:64];
		in_ch.a_low        <= a[63:0];
		in_ch.b_high       <= b[127:64];
		in_ch.b_low        <= b[63:0];
		in_ch.shift_amount <= sh;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic idle_gap(int n);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// receiver: shifting stall patterns, plus one long hold-off to fill the chain
	initial begin
		int mode;
		int cnt;
		out_ch.ready = 1'b0;
		mode = 0;
		cnt = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cnt++;
			if (cnt % 97 == 0) mode = $urandom_range(0, 3);
			if (cnt >= 300 && cnt < 900)
				out_ch.ready <= 1'b0;
			else case (mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 1) == 1);
				2: out_ch.ready <= ($urandom_range(0, 7) == 0);
				default: out_ch.ready <= ((cnt % 5) != 0);
			endcase
		end
	end

	initial begin
		int           burst;
		logic [3:0]   opc;
		logic [127:0] a;
		logic [7:0]   sh;

		in_ch.valid        = 1'b0;
		in_ch.opcode       = '0;
		in_ch.a_high       = '0;
		in_ch.a_low        = '0;
		in_ch.b_high       = '0;
		in_ch.b_low        = '0;
		in_ch.shift_amount = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every opcode and its corners
		send_op(OP_ADD, ALL_ONE, 128'd1, 8'd0);          // wrap to zero
		send_op(OP_SUB, '0, 128'd1, 8'd0);
		send_op(OP_MUL, MIN_NEG, ALL_ONE, 8'd0);
		send_op(OP_MUL, ALL_ONE, ALL_ONE, 8'hff);
		send_op(OP_DIV, MIN_NEG, '0, 8'd0);              // divide by zero
		send_op(OP_DIV, MIN_NEG, ALL_ONE, 8'd0);         // quotient overflow
		send_op(OP_DIV, -128'd7, 128'd2, 8'd0);          // truncation toward zero
		send_op(OP_DIV, 128'd7, -128'd2, 8'd0);
		send_op(OP_DIV, MIN_NEG, MIN_NEG, 8'd0);
		send_op(OP_AND, ALL_ONE, MIN_NEG, 8'd0);
		send_op(OP_OR, '0, ALL_ONE, 8'd0);
		send_op(OP_XOR, ALL_ONE, ALL_ONE, 8'd0);         // equal operands
		send_op(OP_NOT, '0, '0, 8'd0);
		send_op(OP_NEG, MIN_NEG, '0, 8'd0);
		send_op(OP_SHL, ALL_ONE, '0, 8'd0);
		send_op(OP_SHL, ALL_ONE, '0, 8'd64);
		send_op(OP_SHL, ALL_ONE, '0, 8'd127);
		send_op(OP_SHL, ALL_ONE, '0, 8'd128);            // long shift
		send_op(OP_SAR, MIN_NEG, '0, 8'd64);
		send_op(OP_SAR, MIN_NEG, '0, 8'd255);            // long shift, sign fill
		send_op(OP_SAR, 128'd1 << 126, '0, 8'd200);
		send_op(OP_ROL1, MIN_NEG, '0, 8'd0);
		send_op(OP_ROR1, 128'd1, '0, 8'd0);
		send_op(4'd13, ALL_ONE, ALL_ONE, 8'd0);          // unused opcodes
		send_op(4'd15, 128'd5, '0, 8'd0);
		idle_gap(3);

		// random bursts with random gaps
		burst = 0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			opc = 4'($urandom_range(0, 15));
			if (opc > 4'd12 && $urandom_range(0, 3) != 0)
				opc = OP_DIV;
			a = pick_operand();
			sh = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 130));
			send_op(opc, a, ($urandom_range(0, 15) == 0) ? a : pick_operand(), sh);
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 12));
			end else begin
				burst--;
			end
		end
		@(negedge clk);
		in_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
